// File: src/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg: shared types and constants of the shard slot bitmap allocator
// Field widths, default sizes, controller states and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sba_pkg;

  // Default sizes
  localparam int SHARDS_DEF = 16;
  localparam int SLOTS_DEF  = 256;

  // Bitmap memory word: 32 slots per word
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // Fixed field widths of the request and result
  localparam int SHARD_W = 4;
  localparam int SLOT_W  = 8;
  localparam int ENT_W   = 9;

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Index width for a depth, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_LD,
    ST_EVAL,
    ST_WRD,
    ST_WMOD,
    ST_SRD,
    ST_SCHK,
    ST_FIN
  } sba_state_t;

  // How the target slot register moves
  typedef enum logic [2:0] {
    TGT_HOLD,
    TGT_SLOT,
    TGT_ZERO,
    TGT_CNT,
    TGT_NEXT,
    TGT_FOUND
  } sba_tgt_t;

  typedef struct packed {
    logic     load;
    logic     clr_wr;
    logic     cnt_rd;
    logic     cnt_ld;
    sba_tgt_t tgt_op;
    logic     word_rd;
    logic     word_wr;
    logic     cnt_inc;
    logic     mark_app;
    logic     mark_full;
    logic     push;
  } sba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic shard_bad;
    logic slot_bad;
    logic is_del;
    logic known;
    logic cnt_zero;
    logic cnt_full;
    logic found;
    logic last_word;
    logic app;
    logic out_free;
  } sba_sts_t;

endpackage

// File: src/sba_req_if.sv
// ----------------------------------------------------------------------------
// sba_req_if: request channel of the slot allocator
// Valid/ready handshake carrying one access: op, shard, slot_known, slot.
// ----------------------------------------------------------------------------
interface sba_req_if import sba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [SHARD_W-1:0] shard;
  logic               slot_known;
  logic [SLOT_W-1:0]  slot;

  modport source (output valid, output op, output shard, output slot_known,
                  output slot, input ready);
  modport sink   (input valid, input op, input shard, input slot_known,
                  input slot, output ready);
endinterface

// File: src/sba_res_if.sv
// ----------------------------------------------------------------------------
// sba_res_if: result channel of the slot allocator
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface sba_res_if import sba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] assigned_slot;
  logic              appended;
  logic              full_res;
  logic [ENT_W-1:0]  entries;

  modport source (output valid, output assigned_slot, output appended,
                  output full_res, output entries, input ready);
  modport sink   (input valid, input assigned_slot, input appended,
                  input full_res, input entries, output ready);
endinterface

// File: src/shard_slot_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// shard_slot_bitmap_allocator_top: per-shard first-free slot allocator
// Occupancy bitmap and high-water slot count for each shard.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap and count memories to zero, one
// 32-bit word per cycle, and takes no request until the sweep ends. Each
// request then runs alone through a sequencer around single-port-read
// memories: a shard out of range goes straight to its result; a delete, a
// write with a known slot or a write to an empty shard reads the count and
// then reads and rewrites one bitmap word; and a slot search reads the count
// and scans the bitmap words in turn, with one more word read and rewrite
// when it appends. The registered read of each 32-bit bitmap word sets the
// search time. One result is returned per request and waits in an output
// register until taken; a new request can be accepted while it waits.
module shard_slot_bitmap_allocator_top import sba_pkg::*; #(
  parameter int SHARDS = SHARDS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sba_req_if.sink   req,
  sba_res_if.source res
);

  sba_cmd_t cmd;
  sba_sts_t sts;
  logic     in_ready;

  assign req.ready = in_ready;

  sba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sba_datapath #(.SHARDS(SHARDS), .SLOTS(SLOTS)) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

// File: src/sba_ram.sv
// ----------------------------------------------------------------------------
// sba_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sba_ram import sba_pkg::*; #(
  parameter int W  = WORD_W,
  parameter int D  = 128,
  parameter int AW = idx_w(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/sba_datapath.sv
// ----------------------------------------------------------------------------
// sba_datapath: storage and arithmetic of the slot allocator
// Holds the request fields, the bitmap and count memories, the target slot,
// the free-bit search over one bitmap word and the result register.
// ----------------------------------------------------------------------------
module sba_datapath import sba_pkg::*; #(
  parameter int SHARDS = SHARDS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sba_req_if.sink   req,
  sba_res_if.source res,
  input  sba_cmd_t  cmd,
  output sba_sts_t  sts
);

  localparam int WPS    = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = idx_w(WPS);
  localparam int TW     = BIT_W + WIDX_W;
  localparam int WORDS  = SHARDS * WPS;
  localparam int AW     = idx_w(WORDS);
  localparam int SHW    = idx_w(SHARDS);
  localparam int CW     = $clog2(SLOTS + 1);

  logic               op_q;
  logic [SHARD_W-1:0] shard_q;
  logic               known_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [CW-1:0]      cnt_q;
  logic [TW-1:0]      tgt;
  logic               app_q;
  logic               full_q;
  logic [AW-1:0]      clr_addr;

  logic [SHW-1:0]     shard_idx;
  logic [WIDX_W-1:0]  word_idx;
  logic [BIT_W-1:0]   bit_idx;
  logic [AW-1:0]      word_addr;
  logic [WORD_W-1:0]  rd_word;
  logic [WORD_W-1:0]  wr_data;
  logic [BIT_W-1:0]   wr_bit;
  logic [WORD_W-1:0]  free;
  logic [BIT_W-1:0]   found_idx;
  logic [31:0]        word_base;
  logic               clr_in_shards;
  logic [CW-1:0]      cnt_rdata;
  logic               cnt_we;
  logic [SHW-1:0]     cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic               shard_bad;

  assign shard_idx = SHW'(shard_q);
  assign word_idx  = tgt[TW-1:BIT_W];
  assign bit_idx   = tgt[BIT_W-1:0];
  assign word_addr = AW'(32'(shard_idx) * WPS + 32'(word_idx));
  assign word_base = 32'(word_idx) * WORD_W;
  assign shard_bad = 32'(shard_q) >= SHARDS;

  // Capture the request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= req.op;
      shard_q <= req.shard;
      known_q <= req.slot_known;
      slot_q  <= req.slot;
    end
  end

  // Result flags, cleared per request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      app_q  <= 1'b0;
      full_q <= 1'b0;
    end else begin
      if (cmd.mark_app) begin
        app_q <= 1'b1;
      end
      if (cmd.mark_full) begin
        full_q <= 1'b1;
      end
    end
  end

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= AW'(clr_addr + 1'b1);
    end
  end

  // Find the lowest free slot of the word that lies below the count
  always_comb begin
    found_idx = '0;
    for (int b = 0; b < WORD_W; b++) begin
      free[b] = !rd_word[b] && ((word_base + 32'(b)) < 32'(cnt_q));
    end
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free[b]) begin
        found_idx = BIT_W'(b);
      end
    end
  end

  // Set or clear one bit of the word just read; zero during the sweep
  assign wr_bit = (cmd.tgt_op == TGT_FOUND) ? found_idx : bit_idx;

  always_comb begin
    wr_data         = rd_word;
    wr_data[wr_bit] = (op_q != OP_DELETE);
    if (cmd.clr_wr) begin
      wr_data = '0;
    end
  end

  sba_ram #(.W(WORD_W), .D(WORDS)) u_bitmap (
    .clk   (clk),
    .we    (cmd.clr_wr || cmd.word_wr),
    .waddr (cmd.clr_wr ? clr_addr : word_addr),
    .wdata (wr_data),
    .re    (cmd.word_rd),
    .raddr (word_addr),
    .rdata (rd_word)
  );

  // Slot counts: zeroed by the sweep, bumped on append
  assign clr_in_shards = 32'(clr_addr) < SHARDS;
  assign cnt_we        = (cmd.clr_wr && clr_in_shards) || cmd.cnt_inc;
  assign cnt_waddr     = cmd.clr_wr ? SHW'(clr_addr) : shard_idx;
  assign cnt_wdata     = cmd.clr_wr ? '0 : CW'(cnt_q + 1'b1);

  sba_ram #(.W(CW), .D(SHARDS)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.cnt_rd),
    .raddr (shard_idx),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cnt_ld) begin
      cnt_q <= cnt_rdata;
    end else if (cmd.cnt_inc) begin
      cnt_q <= CW'(cnt_q + 1'b1);
    end
  end

  // Move the target slot
  always_ff @(posedge clk) begin
    unique case (cmd.tgt_op)
      TGT_HOLD:  tgt <= tgt;
      TGT_SLOT:  tgt <= TW'(slot_q);
      TGT_ZERO:  tgt <= '0;
      TGT_CNT:   tgt <= TW'(cnt_q);
      TGT_NEXT:  tgt <= {WIDX_W'(word_idx + 1'b1), BIT_W'(0)};
      TGT_FOUND: tgt[BIT_W-1:0] <= found_idx;
      default:   tgt <= tgt;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.push) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res.assigned_slot <= full_q ? '0 : SLOT_W'(tgt);
      res.appended      <= app_q;
      res.full_res      <= full_q;
      res.entries       <= shard_bad ? '0 : ENT_W'(cnt_q);
    end
  end

  // Status to the controller
  always_comb begin
    sts.clr_last  = 32'(clr_addr) == WORDS - 1;
    sts.shard_bad = shard_bad;
    sts.slot_bad  = 32'(slot_q) >= SLOTS;
    sts.is_del    = op_q == OP_DELETE;
    sts.known     = known_q;
    sts.cnt_zero  = cnt_q == '0;
    sts.cnt_full  = 32'(cnt_q) >= SLOTS;
    sts.found     = |free;
    sts.last_word = (word_base + WORD_W) >= 32'(cnt_q);
    sts.app       = app_q;
    sts.out_free  = !res.valid || res.ready;
  end

  a_inc_below_slots: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> 32'(cnt_q) < SLOTS)
    else $error("count bumped past the shard size");

  a_full_not_appended: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.full_res) |-> !res.appended)
    else $error("refused access reported as appended");

  a_write_valid_shard: assert property (@(posedge clk) disable iff (rst)
    cmd.word_wr |-> !shard_bad)
    else $error("bitmap write for a shard out of range");

endmodule

// File: src/sba_ctrl.sv
// ----------------------------------------------------------------------------
// sba_ctrl: sequencer of the slot allocator
// Runs the clearing sweep after reset, then steps each request through the
// count read, the decision, the bitmap read-modify-write or word scan, and
// the hand-off of the result; a shard out of range skips to the hand-off.
// ----------------------------------------------------------------------------
module sba_ctrl import sba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output sba_cmd_t cmd,
  input  sba_sts_t sts
);

  sba_state_t state;
  sba_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.tgt_op = TGT_HOLD;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        if (sts.shard_bad) begin
          cmd.mark_full = 1'b1;
          state_next    = ST_FIN;
        end else begin
          cmd.cnt_rd = 1'b1;
          state_next = ST_CNT_LD;
        end
      end
      ST_CNT_LD: begin
        cmd.cnt_ld = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (sts.is_del || (!sts.cnt_zero && sts.known)) begin
          if (sts.slot_bad) begin
            cmd.mark_full = 1'b1;
            state_next    = ST_FIN;
          end else begin
            cmd.tgt_op = TGT_SLOT;
            state_next = ST_WRD;
          end
        end else if (sts.cnt_zero) begin
          cmd.tgt_op   = TGT_ZERO;
          cmd.mark_app = 1'b1;
          state_next   = ST_WRD;
        end else begin
          cmd.tgt_op = TGT_ZERO;
          state_next = ST_SRD;
        end
      end
      ST_WRD: begin
        cmd.word_rd = 1'b1;
        state_next  = ST_WMOD;
      end
      ST_WMOD: begin
        cmd.word_wr = 1'b1;
        cmd.cnt_inc = sts.app;
        state_next  = ST_FIN;
      end
      ST_SRD: begin
        cmd.word_rd = 1'b1;
        state_next  = ST_SCHK;
      end
      ST_SCHK: begin
        priority if (sts.found) begin
          cmd.tgt_op  = TGT_FOUND;
          cmd.word_wr = 1'b1;
          state_next  = ST_FIN;
        end else if (sts.last_word) begin
          if (sts.cnt_full) begin
            cmd.mark_full = 1'b1;
            state_next    = ST_FIN;
          end else begin
            cmd.tgt_op   = TGT_CNT;
            cmd.mark_app = 1'b1;
            state_next   = ST_WRD;
          end
        end else begin
          cmd.tgt_op = TGT_NEXT;
          state_next = ST_SRD;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.out_free)
    else $error("result pushed over an untaken result");

  a_cnt_rd_valid_shard: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_rd |-> !sts.shard_bad)
    else $error("count read for a shard out of range");

  a_scan_only_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRD) |-> (!sts.cnt_zero && !sts.is_del && !sts.known))
    else $error("word scan entered for an access that needs none");

endmodule
